// File: rtl/tmls_pkg.sv
// Shared types, constants and tables for the terminal mux line scanner.
// Depends on nothing; every other file imports it.
package tmls_pkg;

   // Number of serial lines and the pointer width that follows from it
   localparam int LINES  = 32;
   localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;

   // Field widths of the channels
   localparam int OP_W     = 2;
   localparam int PULSE_W  = 6;
   localparam int IO_W     = 18;
   localparam int EVLINE_W = 5;
   localparam int CHAR_W   = 8;
   localparam int LEVEL_W  = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   // Item kinds on the request channel
   localparam logic [OP_W-1:0] OP_PULSE  = 2'd0;
   localparam logic [OP_W-1:0] OP_RX     = 2'd1;
   localparam logic [OP_W-1:0] OP_TXDONE = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEV_EN  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IRQ_LVL = 1'b1;

   // Pulse decoding: clear bit, selector mask and selector codes (octal)
   localparam logic [PULSE_W-1:0] PULSE_CLR_MASK = 6'o20;
   localparam logic [PULSE_W-1:0] PULSE_SEL_MASK = 6'o57;
   localparam logic [PULSE_W-1:0] SEL_RD_CHAR    = 6'o00;
   localparam logic [PULSE_W-1:0] SEL_RD_LINE    = 6'o01;
   localparam logic [PULSE_W-1:0] SEL_RD_UNLOCK  = 6'o10;
   localparam logic [PULSE_W-1:0] SEL_UNLOCK     = 6'o11;
   localparam logic [PULSE_W-1:0] SEL_TX_SEND    = 6'o40;
   localparam logic [PULSE_W-1:0] SEL_SET_SEND   = 6'o41;
   localparam logic [PULSE_W-1:0] SEL_TX_SCAN    = 6'o50;

   // Number of values of the six-bit send line field
   localparam int SEND_FIELD_N = 64;

   // Command kinds handed from the front end to the back end
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_ILLEGAL,
      CMD_RD_CHAR,
      CMD_RD_LINE,
      CMD_RD_UNLOCK,
      CMD_UNLOCK,
      CMD_TX_SEND,
      CMD_SET_SEND,
      CMD_TX_SCAN,
      CMD_RX,
      CMD_TX_DONE
   } cmd_kind_type;

   // One classified command
   typedef struct packed {
      cmd_kind_type            kind;
      logic [IO_W-1:0]         io;
      logic [LINE_W-1:0]       line;
      logic [CHAR_W-1:0]       chr;
   } cmd_type;

   // Back end sequencer states
   typedef enum logic {
      BK_READ,
      BK_EXEC
   } back_state_type;

   // Send line field reduced modulo LINES, built at elaboration
   typedef logic [LINE_W-1:0] send_tbl_type [SEND_FIELD_N];

   function automatic send_tbl_type build_send_tbl();
      send_tbl_type t;
      for (int i = 0; i < SEND_FIELD_N; i++) begin
         t[i] = LINE_W'(i % LINES);
      end
      return t;
   endfunction

   localparam send_tbl_type SEND_MOD_TBL = build_send_tbl();

endpackage

// File: rtl/tmls_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on tmls_pkg for field widths.
interface tmls_req_if
   import tmls_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       op;
   logic [PULSE_W-1:0]    pulse;
   logic [IO_W-1:0]       io_in;
   logic [EVLINE_W-1:0]   line;
   logic [CHAR_W-1:0]     rx_char;
   logic                  rx_break;

   modport source (output valid, op, pulse, io_in, line, rx_char, rx_break,
                   input ready);
   modport sink   (input valid, op, pulse, io_in, line, rx_char, rx_break,
                   output ready);
endinterface

interface tmls_rsp_if
   import tmls_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [IO_W-1:0]       io_out;
   logic                  illegal;
   logic                  irq_request;
   logic [LEVEL_W-1:0]    irq_level;
   logic                  tx_start;
   logic [EVLINE_W-1:0]   tx_line;
   logic [CHAR_W-1:0]     tx_char;
   logic [EVLINE_W-1:0]   scan_line;
   logic                  scanner_locked;

   modport source (output valid, io_out, illegal, irq_request, irq_level, tx_start,
                   tx_line, tx_char, scan_line, scanner_locked,
                   input ready);
   modport sink   (input valid, io_out, illegal, irq_request, irq_level, tx_start,
                   tx_line, tx_char, scan_line, scanner_locked,
                   output ready);
endinterface

// File: rtl/tmls_front.sv
// Front end: accepts request beats and classifies them into commands.
// Depends on tmls_pkg and tmls_req_if.
module tmls_front
   import tmls_pkg::*;
   (
      tmls_req_if.sink       req_chan,
      input  logic           dev_enabled,
      input  logic           q_full,
      output logic           push,
      output cmd_type        push_cmd
   );

   logic [PULSE_W-1:0]    sel;
   logic [IO_W-1:0]       io_clr;
   logic                  line_ok;

   // Accept whenever the queue has room
   assign req_chan.ready = !q_full;
   assign push           = req_chan.valid && !q_full;

   assign sel     = req_chan.pulse & PULSE_SEL_MASK;
   assign io_clr  = ((req_chan.pulse & PULSE_CLR_MASK) != '0) ? '0 : req_chan.io_in;
   assign line_ok = (int'(req_chan.line) < LINES);

   // Classify the beat
   always_comb begin
      push_cmd.kind = CMD_NONE;
      push_cmd.io   = '0;
      push_cmd.line = LINE_W'(req_chan.line);
      push_cmd.chr  = req_chan.rx_break ? '0 : req_chan.rx_char;
      unique case (req_chan.op)
         OP_PULSE: begin
            if (!dev_enabled) begin
               push_cmd.kind = CMD_ILLEGAL;
               push_cmd.io   = req_chan.io_in;
            end else begin
               push_cmd.io = io_clr;
               unique case (sel)
                  SEL_RD_CHAR:   push_cmd.kind = CMD_RD_CHAR;
                  SEL_RD_LINE:   push_cmd.kind = CMD_RD_LINE;
                  SEL_RD_UNLOCK: push_cmd.kind = CMD_RD_UNLOCK;
                  SEL_UNLOCK:    push_cmd.kind = CMD_UNLOCK;
                  SEL_TX_SEND:   push_cmd.kind = CMD_TX_SEND;
                  SEL_SET_SEND: begin
                     push_cmd.kind = CMD_SET_SEND;
                     push_cmd.line = SEND_MOD_TBL[io_clr[PULSE_W-1:0]];
                  end
                  SEL_TX_SCAN:   push_cmd.kind = CMD_TX_SCAN;
                  default:       push_cmd.kind = CMD_ILLEGAL;
               endcase
            end
         end
         OP_RX: begin
            if (dev_enabled && line_ok) begin
               push_cmd.kind = CMD_RX;
            end
         end
         OP_TXDONE: begin
            if (dev_enabled && line_ok) begin
               push_cmd.kind = CMD_TX_DONE;
            end
         end
         default: push_cmd.kind = CMD_NONE;
      endcase
   end

endmodule

// File: rtl/tmls_cmdq.sv
// Two-entry command queue between the front end and the back end.
// Depends on tmls_pkg for the command type.
module tmls_cmdq
   import tmls_pkg::*;
   (
      input  logic     clock,
      input  logic     reset,
      input  logic     push,
      input  cmd_type  push_cmd,
      input  logic     pop,
      output logic     full,
      output logic     not_empty,
      output cmd_type  head
   );

   cmd_type      entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed commands
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/tmls_back.sv
// Back end: executes commands against line buffers, flags and scanner.
// Depends on tmls_pkg and tmls_rsp_if.
module tmls_back
   import tmls_pkg::*;
   (
      input  logic                 clock,
      input  logic                 reset,
      input  logic [LEVEL_W-1:0]   irq_level_cfg,
      input  logic                 q_not_empty,
      input  cmd_type              q_head,
      output logic                 pop,
      tmls_rsp_if.source           rsp_chan
   );

   back_state_type        state_ff, state_in;

   // Line buffer memory with registered read at the scan pointer
   logic [CHAR_W-1:0]     buf_mem [LINES];
   logic [LINES-1:0]      buf_wr_ff, buf_wr_in;
   logic [CHAR_W-1:0]     rd_data_ff;
   logic                  rd_vld_ff;

   logic [LINES-1:0]      flags_ff, flags_in;
   logic [LINE_W-1:0]     scan_ptr_ff, scan_ptr_in;
   logic [LINE_W-1:0]     send_ptr_ff, send_ptr_in;
   logic                  lock_ff, lock_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IO_W-1:0]       io_out_ff, io_out_in;
   logic                  illegal_ff, illegal_in;
   logic                  irq_ff, irq_in;
   logic                  tx_start_ff, tx_start_in;
   logic [LINE_W-1:0]     tx_line_ff, tx_line_in;
   logic [CHAR_W-1:0]     tx_char_ff, tx_char_in;

   logic                  out_free;
   logic                  exec;
   logic                  wr_en;
   logic [LINE_W-1:0]     wr_addr;
   logic [CHAR_W-1:0]     wr_data;
   logic [LINES-1:0]      flags_mod;
   logic [CHAR_W-1:0]     rd_char;
   logic                  scan_go, scan_unlock;
   logic                  hit_hi, hit_lo;
   logic [LINE_W-1:0]     idx_hi, idx_lo;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign rd_char  = rd_vld_ff ? rd_data_ff : '0;

   // Next state: read the buffer in BK_READ, then execute in BK_EXEC
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_READ: if (q_not_empty) state_in = BK_EXEC;
         BK_EXEC: if (q_not_empty && out_free) state_in = BK_READ;
         default: state_in = BK_READ;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      exec = 1'b0;
      unique case (state_ff)
         BK_READ: exec = 1'b0;
         BK_EXEC: exec = q_not_empty && out_free;
         default: exec = 1'b0;
      endcase
   end

   assign pop = exec;

   // Carry out the command
   always_comb begin
      flags_mod   = flags_ff;
      wr_en       = 1'b0;
      wr_addr     = q_head.line;
      wr_data     = q_head.chr;
      io_out_in   = q_head.io;
      illegal_in  = 1'b0;
      tx_start_in = 1'b0;
      tx_line_in  = '0;
      tx_char_in  = '0;
      send_ptr_in = send_ptr_ff;
      scan_go     = 1'b0;
      scan_unlock = 1'b0;
      case (q_head.kind)
         CMD_NONE: io_out_in = '0;
         CMD_ILLEGAL: illegal_in = 1'b1;
         CMD_RD_CHAR: begin
            io_out_in = q_head.io | IO_W'(rd_char);
            flags_mod[scan_ptr_ff] = 1'b0;
         end
         CMD_RD_LINE: io_out_in = q_head.io | IO_W'(scan_ptr_ff);
         CMD_RD_UNLOCK: begin
            io_out_in = q_head.io | IO_W'(rd_char);
            flags_mod[scan_ptr_ff] = 1'b0;
            scan_go     = 1'b1;
            scan_unlock = 1'b1;
         end
         CMD_UNLOCK: begin
            scan_go     = 1'b1;
            scan_unlock = 1'b1;
         end
         CMD_TX_SEND: begin
            wr_en       = 1'b1;
            wr_addr     = send_ptr_ff;
            wr_data     = q_head.io[CHAR_W-1:0];
            flags_mod[send_ptr_ff] = 1'b0;
            tx_start_in = 1'b1;
            tx_line_in  = send_ptr_ff;
            tx_char_in  = q_head.io[CHAR_W-1:0];
         end
         CMD_SET_SEND: send_ptr_in = q_head.line;
         CMD_TX_SCAN: begin
            wr_en       = 1'b1;
            wr_addr     = scan_ptr_ff;
            wr_data     = q_head.io[CHAR_W-1:0];
            flags_mod[scan_ptr_ff] = 1'b0;
            tx_start_in = 1'b1;
            tx_line_in  = scan_ptr_ff;
            tx_char_in  = q_head.io[CHAR_W-1:0];
            scan_go     = 1'b1;
            scan_unlock = 1'b1;
         end
         CMD_RX: begin
            io_out_in = '0;
            wr_en     = 1'b1;
            flags_mod[q_head.line] = 1'b1;
            scan_go   = !lock_ff;
         end
         CMD_TX_DONE: begin
            io_out_in = '0;
            flags_mod[q_head.line] = 1'b1;
            scan_go   = !lock_ff;
         end
         default: io_out_in = '0;
      endcase
   end

   // Round-robin search: first flag above the pointer, else the lowest flag
   always_comb begin
      hit_hi = 1'b0;
      hit_lo = 1'b0;
      idx_hi = '0;
      idx_lo = '0;
      for (int i = LINES - 1; i >= 0; i--) begin
         if (flags_mod[i]) begin
            hit_lo = 1'b1;
            idx_lo = LINE_W'(i);
            if (LINE_W'(i) > scan_ptr_ff) begin
               hit_hi = 1'b1;
               idx_hi = LINE_W'(i);
            end
         end
      end
   end

   // Scanner update
   always_comb begin
      scan_ptr_in = scan_ptr_ff;
      lock_in     = lock_ff;
      irq_in      = 1'b0;
      if (scan_go) begin
         if (hit_lo) begin
            scan_ptr_in = hit_hi ? idx_hi : idx_lo;
            lock_in     = 1'b1;
            irq_in      = 1'b1;
         end else if (scan_unlock) begin
            lock_in = 1'b0;
         end
      end
   end

   // Buffer write marks and flags
   always_comb begin
      buf_wr_in = buf_wr_ff;
      flags_in  = flags_ff;
      if (exec) begin
         flags_in = flags_mod;
         if (wr_en) begin
            buf_wr_in[wr_addr] = 1'b1;
         end
      end
   end

   // Hold the result until taken; load a new one on execute
   assign rsp_valid_in = exec || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_READ;
         buf_wr_ff    <= '0;
         flags_ff     <= '0;
         scan_ptr_ff  <= '0;
         send_ptr_ff  <= '0;
         lock_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         buf_wr_ff    <= buf_wr_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec) begin
            scan_ptr_ff <= scan_ptr_in;
            send_ptr_ff <= send_ptr_in;
            lock_ff     <= lock_in;
         end
      end
   end

   // Memory port and registered read
   always_ff @(posedge clock) begin
      if (exec && wr_en) begin
         buf_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= buf_mem[scan_ptr_ff];
      rd_vld_ff  <= buf_wr_ff[scan_ptr_ff];
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (exec) begin
         io_out_ff   <= io_out_in;
         illegal_ff  <= illegal_in;
         irq_ff      <= irq_in;
         tx_start_ff <= tx_start_in;
         tx_line_ff  <= tx_line_in;
         tx_char_ff  <= tx_char_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.io_out         = io_out_ff;
   assign rsp_chan.illegal        = illegal_ff;
   assign rsp_chan.irq_request    = irq_ff;
   assign rsp_chan.irq_level      = irq_ff ? irq_level_cfg : '0;
   assign rsp_chan.tx_start       = tx_start_ff;
   assign rsp_chan.tx_line        = EVLINE_W'(tx_line_ff);
   assign rsp_chan.tx_char        = tx_char_ff;
   assign rsp_chan.scan_line      = EVLINE_W'(scan_ptr_ff);
   assign rsp_chan.scanner_locked = lock_ff;

endmodule

// File: rtl/terminal_mux_line_scanner.sv
// Top level of the terminal mux line scanner: config registers and wiring.
// Depends on tmls_pkg, tmls_if, tmls_front, tmls_cmdq and tmls_back.
//
//   channel    direction   handshake           beat contents
//   req_chan   in          valid/ready         op, pulse, io_in, line, rx_char, rx_break
//   rsp_chan   out         valid/ready         io_out, illegal, irq, tx, scan status
//   csr_*      in          csr_we only         csr_index, csr_wdata
//
// In the back end each item goes through BK_READ, which reads the line buffer
// memory at the scan pointer, then BK_EXEC, which executes and loads the result register.
// The front end accepts into a two-entry queue while the back end works.
// Reset is synchronous and clears flags, pointers, lock and buffer marks.
// A stalled response holds in its register; the queue fills, then req stalls.
module terminal_mux_line_scanner
   import tmls_pkg::*;
   (
      input  logic                    clock,
      input  logic                    reset,
      tmls_req_if.sink                req_chan,
      tmls_rsp_if.source              rsp_chan,
      input  logic                    csr_we,
      input  logic [CSR_IDX_W-1:0]    csr_index,
      input  logic [CSR_DATA_W-1:0]   csr_wdata
   );

   logic                  dev_en_ff, dev_en_in;
   logic [LEVEL_W-1:0]    irq_lvl_ff, irq_lvl_in;

   logic                  push, pop, q_full, q_not_empty;
   cmd_type               push_cmd, q_head;

   // Decode configuration writes
   always_comb begin
      dev_en_in  = dev_en_ff;
      irq_lvl_in = irq_lvl_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEV_EN:  dev_en_in  = csr_wdata[0];
            CSR_IRQ_LVL: irq_lvl_in = csr_wdata[LEVEL_W-1:0];
            default:     dev_en_in  = dev_en_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_en_ff  <= 1'b0;
         irq_lvl_ff <= '0;
      end else begin
         dev_en_ff  <= dev_en_in;
         irq_lvl_ff <= irq_lvl_in;
      end
   end

   tmls_front u_front (
      .req_chan    (req_chan),
      .dev_enabled (dev_en_ff),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   tmls_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   tmls_back u_back (
      .clock         (clock),
      .reset         (reset),
      .irq_level_cfg (irq_lvl_ff),
      .q_not_empty   (q_not_empty),
      .q_head        (q_head),
      .pop           (pop),
      .rsp_chan      (rsp_chan)
   );

endmodule
